// ----- hdl/grm_pkg.sv -----
// Package: shared types, codes and tables of the greedy rectangle merger.
package grm_pkg;

	localparam int unsigned CellW = 24;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_PULL = 2'd1,
		KIND_NEW  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_FACE  = 3'd0,
		REG_LAYER = 3'd1,
		REG_WIDTH = 3'd2,
		REG_HEIGHT = 3'd3,
		REG_DEPTH = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_GROW_U_RD,
		ST_GROW_U_CHK,
		ST_GROW_V_RD,
		ST_GROW_V_CHK,
		ST_WIPE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] cell_u;
		logic [5:0] cell_v;
		logic [7:0] voxel_code;
		logic [7:0] dark_corners;
		logic [7:0] bright_corners;
	} req_t;

	typedef struct packed {
		logic [23:0] position_word;
		logic [17:0] attribute_word;
		logic [19:0] quad_base_vertex;
		logic        last_vertex;
		logic        scan_done;
	} result_t;

	// corner pick, per face and corner, bits {x,y,z} as [2]=a0 [1]=a1 [0]=a2
	function automatic logic [2:0] corner_pick(input logic [2:0] fd, input logic [1:0] i);
		logic [11:0] row;
		begin
			unique case (fd)
				3'd0: row = {3'b110, 3'b111, 3'b101, 3'b100};
				3'd1: row = {3'b001, 3'b011, 3'b010, 3'b000};
				3'd2: row = {3'b011, 3'b111, 3'b110, 3'b010};
				3'd3: row = {3'b100, 3'b101, 3'b001, 3'b000};
				3'd4: row = {3'b101, 3'b111, 3'b011, 3'b001};
				default: row = {3'b000, 3'b010, 3'b110, 3'b100};
			endcase
			corner_pick = row[3*i +: 3];
		end
	endfunction

	function automatic logic [1:0] wind_map(input logic [2:0] fd, input logic [1:0] i);
		logic [7:0] row;
		begin
			unique case (fd) inside
				3'd0, 3'd2: row = {2'd2, 2'd3, 2'd1, 2'd0};
				3'd5: row = {2'd0, 2'd2, 2'd3, 2'd1};
				default: row = {2'd1, 2'd3, 2'd2, 2'd0};
			endcase
			wind_map = row[2*i +: 2];
		end
	endfunction

	function automatic logic [1:0] occl_slot(input logic [1:0] k);
		logic [7:0] row;
		begin
			row = {2'd2, 2'd3, 2'd1, 2'd0};
			occl_slot = row[2*k +: 2];
		end
	endfunction

	function automatic logic [3:0] corner_bits(input logic [7:0] lv, input logic [2:0] fd);
		logic [3:0] m;
		logic [1:0] s;
		begin
			m = '0;
			for (int i = 0; i < 4; i++) begin
				s = occl_slot(wind_map(fd, 2'(i)));
				m[i] = (lv[2*s +: 2] != 2'd0);
			end
			corner_bits = m;
		end
	endfunction

endpackage

// ----- hdl/grm_ram.sv -----
// Generic single-port RAM with registered read.
module grm_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- hdl/greedy_rect_merge_quads_unit.sv -----
// Top level: greedy rectangle merger emitting quad vertices from a layer mask.
//
// channel | ports                          | handshake
// request | start, req, busy               | accepted when start && !busy
// result  | res_valid, res                 | one cycle strobe, no back-pressure
// config  | cfg_we, cfg_index, cfg_data    | write when cfg_we
//
// A load registers the request and then writes its cell; a pull reads cells during
// scan and growth and clears each covered cell, all through the single mask memory
// port, then emits four vertices. After reset and after each new-mesh request the
// mask is cleared, one cell per cycle with busy high.
// Results cannot be stalled.
module greedy_rect_merge_quads_unit #(
	parameter int unsigned MAX_SIDE = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  grm_pkg::req_t      req,
	output logic               busy,
	output logic               res_valid,
	output grm_pkg::result_t   res,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [6:0]         cfg_data
);
	localparam int unsigned CW = $clog2(MAX_SIDE) + 1;
	localparam int unsigned AW = 2 * $clog2(MAX_SIDE);
	localparam int unsigned CELLS = 1 << AW;
	localparam int unsigned SB = $clog2(MAX_SIDE);

	grm_pkg::state_t st_q, st_d;

	logic [2:0] face_q;
	logic [5:0] layer_q;
	logic [6:0] wid_q, hgt_q, dep_q;

	logic [CW-1:0] su_q, sv_q;
	logic [CW-1:0] u_q, v_q, w_q, h_q, du_q, dv_q;
	logic [CW-1:0] u_d, v_d, w_d, h_d, du_d, dv_d, su_d, sv_d;
	logic [AW:0]   clr_q, clr_d;
	logic [19:0]   vc_q, vc_d;
	logic [1:0]    vi_q, vi_d;
	logic [23:0]   c_q, c_d;
	logic          load_q, load_d;
	grm_pkg::req_t req_q, req_d;

	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	logic [23:0]      ram_wdata, ram_rdata;

	logic [CW-1:0] wd, ht;
	logic [2:0]    fd;

	grm_ram #(.WIDTH(grm_pkg::CellW), .DEPTH(CELLS)) u_mask (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] u, input logic [CW-1:0] v);
		addr_of = {v[SB-1:0], u[SB-1:0]};
	endfunction

	always_comb begin
		wd = (8'(wid_q) > 8'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(wid_q);
		ht = (8'(hgt_q) > 8'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(hgt_q);
		fd = (face_q >= 3'd6) ? face_q - 3'd2 : face_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q  <= '0;
			layer_q <= '0;
			wid_q   <= 7'd64;
			hgt_q   <= 7'd64;
			dep_q   <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grm_pkg::REG_FACE:   face_q  <= cfg_data[2:0];
				grm_pkg::REG_LAYER:  layer_q <= cfg_data[5:0];
				grm_pkg::REG_WIDTH:  wid_q   <= cfg_data;
				grm_pkg::REG_HEIGHT: hgt_q   <= cfg_data;
				grm_pkg::REG_DEPTH:  dep_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= grm_pkg::ST_CLEAR;
			clr_q  <= '0;
			su_q   <= '0;
			sv_q   <= '0;
			vc_q   <= '0;
			load_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			clr_q  <= clr_d;
			su_q   <= su_d;
			sv_q   <= sv_d;
			vc_q   <= vc_d;
			load_q <= load_d;
		end
	end

	always_ff @(posedge clk) begin
		u_q <= u_d; v_q <= v_d; w_q <= w_d; h_q <= h_d;
		du_q <= du_d; dv_q <= dv_d; vi_q <= vi_d; c_q <= c_d; req_q <= req_d;
	end

	logic [6:0] dlo, dhi;
	logic [6:0] lo [3];
	logic [6:0] hi [3];
	logic [2:0] pk;
	logic [6:0] q [3];
	logic [3:0] dm, bm;

	always_comb begin
		dlo = fd[0] ? 7'(dep_q - 7'd1 - 7'(layer_q)) : 7'(layer_q);
		dhi = dlo + 7'd1;
		unique case (fd[2:1])
			2'd0: begin
				lo[0] = dlo; lo[1] = 7'(v_q); lo[2] = 7'(u_q);
				hi[0] = dhi; hi[1] = 7'(v_q + h_q); hi[2] = 7'(u_q + w_q);
			end
			2'd1: begin
				lo[0] = 7'(u_q); lo[1] = dlo; lo[2] = 7'(v_q);
				hi[0] = 7'(u_q + w_q); hi[1] = dhi; hi[2] = 7'(v_q + h_q);
			end
			default: begin
				lo[0] = 7'(u_q); lo[1] = 7'(v_q); lo[2] = dlo;
				hi[0] = 7'(u_q + w_q); hi[1] = 7'(v_q + h_q); hi[2] = dhi;
			end
		endcase
		pk = grm_pkg::corner_pick(fd, vi_q);
		q[0] = pk[2] ? hi[0] : lo[0];
		q[1] = pk[1] ? hi[1] : lo[1];
		q[2] = pk[0] ? hi[2] : lo[2];
		dm = grm_pkg::corner_bits(c_q[15:8], fd);
		bm = grm_pkg::corner_bits(c_q[23:16], fd);
	end

	always_comb begin
		st_d = st_q; clr_d = clr_q; su_d = su_q; sv_d = sv_q; vc_d = vc_q;
		load_d = load_q;
		u_d = u_q; v_d = v_q; w_d = w_q; h_d = h_q; du_d = du_q; dv_d = dv_q;
		vi_d = vi_q; c_d = c_q; req_d = req_q;
		ram_we = 1'b0; ram_addr = addr_of(u_q + du_q, v_q + dv_q); ram_wdata = '0;
		busy = 1'b1; res_valid = 1'b0; res = '0;
		unique case (st_q)
			grm_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (load_q) begin
					load_d = 1'b0;
					ram_we = 1'b1;
					ram_addr = addr_of(CW'(req_q.cell_u), CW'(req_q.cell_v));
					ram_wdata = {req_q.bright_corners, req_q.dark_corners, req_q.voxel_code};
					busy = 1'b1;
				end else if (start) begin
					req_d = req;
					unique case (grm_pkg::kind_t'(req.kind))
						grm_pkg::KIND_LOAD: begin
							load_d = (8'(req.cell_u) < 8'(MAX_SIDE)) &&
								(8'(req.cell_v) < 8'(MAX_SIDE));
						end
						grm_pkg::KIND_NEW: begin
							su_d = '0; sv_d = '0; vc_d = '0; clr_d = '0;
							st_d = grm_pkg::ST_CLEAR;
						end
						grm_pkg::KIND_PULL: begin
							u_d = su_q; v_d = sv_q; du_d = '0; dv_d = '0;
							st_d = grm_pkg::ST_SCAN_RD;
						end
						default: ;
					endcase
				end
			end
			grm_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q[AW-1:0];
				clr_d = clr_q + 1'b1;
				if (clr_q == (AW+1)'(CELLS - 1)) st_d = grm_pkg::ST_IDLE;
			end
			grm_pkg::ST_SCAN_RD: begin
				if (v_q >= ht) begin
					su_d = '0; sv_d = '0;
					res_valid = 1'b1;
					res.scan_done = 1'b1;
					st_d = grm_pkg::ST_IDLE;
				end else if (u_q >= wd) begin
					u_d = '0; v_d = v_q + 1'b1;
				end else begin
					ram_addr = addr_of(u_q, v_q);
					st_d = grm_pkg::ST_SCAN_CHK;
				end
			end
			grm_pkg::ST_SCAN_CHK: begin
				if (ram_rdata[7:0] == 8'd0) begin
					u_d = u_q + 1'b1;
					st_d = grm_pkg::ST_SCAN_RD;
				end else begin
					c_d = ram_rdata; w_d = CW'(1); h_d = CW'(1);
					st_d = grm_pkg::ST_GROW_U_RD;
				end
			end
			grm_pkg::ST_GROW_U_RD: begin
				if (u_q + w_q >= wd) begin
					du_d = '0;
					st_d = grm_pkg::ST_GROW_V_RD;
				end else begin
					ram_addr = addr_of(u_q + w_q, v_q);
					st_d = grm_pkg::ST_GROW_U_CHK;
				end
			end
			grm_pkg::ST_GROW_U_CHK: begin
				if (ram_rdata == c_q) begin
					w_d = w_q + 1'b1;
					st_d = grm_pkg::ST_GROW_U_RD;
				end else begin
					du_d = '0;
					st_d = grm_pkg::ST_GROW_V_RD;
				end
			end
			grm_pkg::ST_GROW_V_RD: begin
				if (v_q + h_q >= ht) begin
					du_d = '0; dv_d = '0;
					st_d = grm_pkg::ST_WIPE;
				end else begin
					ram_addr = addr_of(u_q + du_q, v_q + h_q);
					st_d = grm_pkg::ST_GROW_V_CHK;
				end
			end
			grm_pkg::ST_GROW_V_CHK: begin
				if (ram_rdata != c_q) begin
					du_d = '0; dv_d = '0;
					st_d = grm_pkg::ST_WIPE;
				end else if (du_q + 1'b1 == w_q) begin
					du_d = '0; h_d = h_q + 1'b1;
					st_d = grm_pkg::ST_GROW_V_RD;
				end else begin
					du_d = du_q + 1'b1;
					st_d = grm_pkg::ST_GROW_V_RD;
				end
			end
			grm_pkg::ST_WIPE: begin
				ram_we = 1'b1;
				ram_addr = addr_of(u_q + du_q, v_q + dv_q);
				if (du_q + 1'b1 == w_q) begin
					du_d = '0;
					dv_d = dv_q + 1'b1;
					if (dv_q + 1'b1 == h_q) begin
						vi_d = '0;
						if (u_q + 1'b1 < wd) begin
							su_d = u_q + 1'b1; sv_d = v_q;
						end else begin
							su_d = '0; sv_d = v_q + 1'b1;
						end
						st_d = grm_pkg::ST_EMIT;
					end
				end else begin
					du_d = du_q + 1'b1;
				end
			end
			grm_pkg::ST_EMIT: begin
				res_valid = 1'b1;
				res.position_word = {fd, q[2], q[1], q[0]};
				res.attribute_word = {vi_q, bm, dm, c_q[7:0]};
				res.quad_base_vertex = vc_q;
				res.last_vertex = (vi_q == 2'd3);
				vi_d = vi_q + 1'b1;
				if (vi_q == 2'd3) begin
					vc_d = vc_q + 20'd4;
					st_d = grm_pkg::ST_IDLE;
				end
			end
			default: st_d = grm_pkg::ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == grm_pkg::ST_IDLE) |-> !res_valid) else $error("result while idle");
	a_done_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.scan_done) |=> !res_valid) else $error("done not alone");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last_vertex) |=> (st_q == grm_pkg::ST_IDLE))
		else $error("quad did not end");
	a_no_write_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !ram_we) else $error("mask write during emit");
`endif
endmodule

// ----- tb/tb_greedy_rect_merge_quads_unit.sv -----
// Testbench: greedy rectangle merger checked against a built-in quad predictor.
`timescale 1ns / 1ps

module tb_greedy_rect_merge_quads_unit;

	localparam int Side     = 64;
	localparam int Limit    = 200000;
	localparam int RandGoal = 330;

	localparam bit [2:0] PICK [6][4] = '{
		'{3'b100, 3'b101, 3'b111, 3'b110},
		'{3'b000, 3'b010, 3'b011, 3'b001},
		'{3'b010, 3'b110, 3'b111, 3'b011},
		'{3'b000, 3'b001, 3'b101, 3'b100},
		'{3'b001, 3'b011, 3'b111, 3'b101},
		'{3'b100, 3'b110, 3'b010, 3'b000}};
	localparam int WIND [6][4] = '{
		'{0, 1, 3, 2}, '{0, 2, 3, 1}, '{0, 1, 3, 2},
		'{0, 2, 3, 1}, '{0, 2, 3, 1}, '{1, 3, 2, 0}};
	localparam int SLOT [4] = '{0, 1, 3, 2};

	logic                clk;
	logic                arst_n;
	logic                start;
	grm_pkg::req_t       req;
	logic                busy;
	logic                res_valid;
	grm_pkg::result_t    res;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [6:0]          cfg_data;

	logic [23:0]         cells [Side*Side];
	int                  scan_u, scan_v;
	logic [19:0]         vcount;
	int                  r_face, r_layer, r_width, r_height, r_depth;
	bit                  pull_done;
	grm_pkg::result_t    vertex_q [$];
	int                  failures;
	int                  items;
	int                  idle_cycles;

	greedy_rect_merge_quads_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.res_valid(res_valid), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [3:0] corner_mask(logic [7:0] lv, int fd);
		logic [3:0] m;
		int s;
		m = '0;
		for (int i = 0; i < 4; i++) begin
			s = SLOT[WIND[fd][i]];
			m[i] = (lv[2*s +: 2] != 2'd0);
		end
		return m;
	endfunction

	function automatic grm_pkg::req_t mk(grm_pkg::kind_t k, int u, int v, int code, int dk,
		int br);
		grm_pkg::req_t r;
		r.kind = k;
		r.cell_u = 6'(u);
		r.cell_v = 6'(v);
		r.voxel_code = 8'(code);
		r.dark_corners = 8'(dk);
		r.bright_corners = 8'(br);
		return r;
	endfunction

	task automatic predict_pull();
		int wd, ht, fd, u, v, fu, fv, w, h, dlo, dhi, q;
		int lo [3];
		int hi [3];
		bit hit, ok;
		logic [23:0] c;
		logic [3:0] dm, bm;
		logic [31:0] pos;
		grm_pkg::result_t e;
		wd = (r_width > Side) ? Side : r_width;
		ht = (r_height > Side) ? Side : r_height;
		fd = (r_face >= 6) ? r_face - 2 : r_face;
		hit = 0;
		fu = 0;
		fv = 0;
		for (v = scan_v; v < ht && !hit; v++)
			for (u = (v == scan_v) ? scan_u : 0; u < wd && !hit; u++)
				if (cells[v*Side+u][7:0] != 8'd0) begin
					hit = 1;
					fu = u;
					fv = v;
				end
		if (!hit) begin
			scan_u = 0;
			scan_v = 0;
			e = '0;
			e.scan_done = 1'b1;
			vertex_q.insert(vertex_q.size(), e);
			pull_done = 1;
			return;
		end
		c = cells[fv*Side+fu];
		w = 1;
		while (fu + w < wd && cells[fv*Side+fu+w] == c)
			w++;
		h = 1;
		ok = 1;
		while (ok && fv + h < ht) begin
			for (int du = 0; du < w; du++)
				if (cells[(fv+h)*Side+fu+du] != c)
					ok = 0;
			if (ok)
				h++;
		end
		for (int dv = 0; dv < h; dv++)
			for (int du = 0; du < w; du++)
				cells[(fv+dv)*Side+fu+du] = '0;
		if (fu + 1 < wd) begin
			scan_u = fu + 1;
			scan_v = fv;
		end else begin
			scan_u = 0;
			scan_v = fv + 1;
		end
		dlo = (fd % 2 == 0) ? r_layer : (r_depth - 1 - r_layer);
		dlo &= 127;
		dhi = (dlo + 1) & 127;
		if (fd / 2 == 0) begin
			lo = '{dlo, fv, fu};
			hi = '{dhi, fv + h, fu + w};
		end else if (fd / 2 == 1) begin
			lo = '{fu, dlo, fv};
			hi = '{fu + w, dhi, fv + h};
		end else begin
			lo = '{fu, fv, dlo};
			hi = '{fu + w, fv + h, dhi};
		end
		dm = corner_mask(c[15:8], fd);
		bm = corner_mask(c[23:16], fd);
		for (int i = 0; i < 4; i++) begin
			pos = 32'(fd) << 21;
			for (int a = 0; a < 3; a++) begin
				q = PICK[fd][i][2-a] ? hi[a] : lo[a];
				pos |= 32'(q & 127) << (7 * a);
			end
			e.position_word = pos[23:0];
			e.attribute_word = {2'(i), bm, dm, c[7:0]};
			e.quad_base_vertex = vcount;
			e.last_vertex = (i == 3);
			e.scan_done = 1'b0;
			vertex_q.insert(vertex_q.size(), e);
		end
		vcount = vcount + 20'd4;
	endtask

	task automatic predict(grm_pkg::req_t r);
		pull_done = 0;
		case (r.kind)
			grm_pkg::KIND_LOAD: cells[int'(r.cell_v)*Side+int'(r.cell_u)] =
				{r.bright_corners, r.dark_corners, r.voxel_code};
			grm_pkg::KIND_NEW: begin
				foreach (cells[i]) cells[i] = '0;
				scan_u = 0;
				scan_v = 0;
				vcount = '0;
			end
			grm_pkg::KIND_PULL: predict_pull();
			default: ;
		endcase
	endtask

	task automatic send(grm_pkg::req_t r);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		predict(r);
		if (r.kind != grm_pkg::KIND_NONE)
			items++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		repeat (2) @(posedge clk);
		while (vertex_q.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(int fc, int ly, int wd, int ht, int dp);
		int vals [5];
		vals = '{fc, ly, wd, ht, dp};
		wait_idle();
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= 7'(vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		r_face = fc & 7;
		r_layer = ly & 63;
		r_width = wd & 127;
		r_height = ht & 127;
		r_depth = dp & 127;
	endtask

	task automatic pull_until_done();
		int n;
		n = 0;
		do begin
			send(mk(grm_pkg::KIND_PULL, $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)));
			n++;
		end while (!pull_done && n < 5000);
	endtask

	task automatic test_empty_pull();
		pull_until_done();
	endtask

	task automatic test_load_extremes();
		send(mk(grm_pkg::KIND_LOAD, 0, 0, 255, 255, 0));
		send(mk(grm_pkg::KIND_LOAD, 63, 63, 1, 0, 255));
		send(mk(grm_pkg::KIND_LOAD, 63, 0, 128, 8'h55, 8'hAA));
		send(mk(grm_pkg::KIND_LOAD, 0, 63, 127, 8'hAA, 8'h55));
		send(mk(grm_pkg::KIND_LOAD, 1, 0, 255, 255, 0));
		send(mk(grm_pkg::KIND_LOAD, 2, 0, 0, 255, 255));
		send(mk(grm_pkg::KIND_NONE, 5, 5, 9, 9, 9));
		pull_until_done();
	endtask

	task automatic test_faces();
		for (int f = 0; f < 8; f++) begin
			configure(f, (f == 1) ? 0 : f * 9, 4, 3, (f == 1) ? 0 : 127 - f);
			send(mk(grm_pkg::KIND_LOAD, 0, 0, 7, 8'h1B, 8'hE4));
			send(mk(grm_pkg::KIND_LOAD, 1, 0, 7, 8'h1B, 8'hE4));
			send(mk(grm_pkg::KIND_LOAD, 0, 1, 7, 8'h1B, 8'hE4));
			send(mk(grm_pkg::KIND_LOAD, 1, 1, 7, 8'h1B, 8'hE4));
			send(mk(grm_pkg::KIND_LOAD, 3, 2, 200, 8'h03 << (2 * (f % 4)),
				8'hC0 >> (2 * (f % 4))));
			pull_until_done();
		end
	endtask

	task automatic test_extents();
		configure(0, 63, 0, 64, 64);
		send(mk(grm_pkg::KIND_LOAD, 0, 0, 5, 0, 0));
		pull_until_done();
		configure(3, 63, 127, 127, 1);
		send(mk(grm_pkg::KIND_LOAD, 63, 62, 9, 255, 255));
		send(mk(grm_pkg::KIND_LOAD, 63, 63, 9, 255, 255));
		pull_until_done();
		send(mk(grm_pkg::KIND_NEW, 0, 0, 0, 0, 0));
		configure(4, 1, 8, 2, 2);
		send(mk(grm_pkg::KIND_LOAD, 5, 0, 3, 0, 0));
		send(mk(grm_pkg::KIND_LOAD, 6, 0, 4, 0, 0));
		send(mk(grm_pkg::KIND_LOAD, 1, 1, 6, 1, 2));
		send(mk(grm_pkg::KIND_PULL, 0, 0, 0, 0, 0));
		configure(4, 1, 4, 2, 2);
		pull_until_done();
	endtask

	task automatic test_new_mesh();
		configure(2, 10, 3, 3, 20);
		send(mk(grm_pkg::KIND_LOAD, 0, 0, 11, 1, 1));
		send(mk(grm_pkg::KIND_LOAD, 2, 2, 12, 2, 2));
		send(mk(grm_pkg::KIND_PULL, 0, 0, 0, 0, 0));
		send(mk(grm_pkg::KIND_NEW, 0, 0, 0, 0, 0));
		pull_until_done();
		send(mk(grm_pkg::KIND_LOAD, 1, 1, 13, 3, 3));
		pull_until_done();
	endtask

	task automatic test_random();
		int phase, wd, ht, n;
		int code [3];
		int dk [3];
		int br [3];
		int p;
		phase = 0;
		while (items < RandGoal) begin
			if (phase % 6 == 5) begin
				wd = 64;
				ht = 64;
			end else begin
				wd = $urandom_range(1, 6);
				ht = $urandom_range(1, 6);
			end
			configure($urandom_range(0, 7), $urandom_range(0, 127), wd, ht,
				$urandom_range(0, 127));
			for (int k = 0; k < 3; k++) begin
				code[k] = (k == 0) ? 0 : $urandom_range(1, 255);
				dk[k] = $urandom_range(0, 255);
				br[k] = $urandom_range(0, 255);
			end
			if (phase % 6 == 5) begin
				for (int k = 0; k < 10; k++) begin
					p = $urandom_range(1, 2);
					send(mk(grm_pkg::KIND_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
						code[p], dk[p], br[p]));
				end
			end else begin
				for (int v = 0; v < ht; v++)
					for (int u = 0; u < wd; u++) begin
						p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
						if ($urandom_range(0, 1) == 0)
							p = 1;
						send(mk(grm_pkg::KIND_LOAD, u, v, code[p], dk[p], br[p]));
					end
			end
			n = $urandom_range(0, 3);
			for (int k = 0; k < n; k++)
				send(mk(grm_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255)));
			pull_until_done();
			phase++;
		end
	endtask

	always @(posedge clk) begin
		grm_pkg::result_t e;
		if (res_valid) begin
			if (vertex_q.size() == 0) begin
				$error("unexpected result %h", res);
				failures++;
			end else begin
				e = vertex_q.pop_front();
				if (res.position_word !== e.position_word) begin
					$error("position_word expected %h actual %h", e.position_word, res.position_word);
					failures++;
				end
				if (res.attribute_word !== e.attribute_word) begin
					$error("attribute_word expected %h actual %h", e.attribute_word, res.attribute_word);
					failures++;
				end
				if (res.quad_base_vertex !== e.quad_base_vertex) begin
					$error("quad_base_vertex expected %h actual %h",
						e.quad_base_vertex, res.quad_base_vertex);
					failures++;
				end
				if (res.last_vertex !== e.last_vertex) begin
					$error("last_vertex expected %b actual %b", e.last_vertex, res.last_vertex);
					failures++;
				end
				if (res.scan_done !== e.scan_done) begin
					$error("scan_done expected %b actual %b", e.scan_done, res.scan_done);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (res_valid || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= Limit) begin
			$display("greedy_rect_merge_quads_unit test failed");
			$finish;
		end
	end

	initial begin
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		failures = 0;
		items = 0;
		idle_cycles = 0;
		pull_done = 0;
		foreach (cells[i]) cells[i] = '0;
		scan_u = 0;
		scan_v = 0;
		vcount = '0;
		r_face = 0;
		r_layer = 0;
		r_width = 64;
		r_height = 64;
		r_depth = 64;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_pull();
		test_load_extremes();
		test_faces();
		test_extents();
		test_new_mesh();
		test_random();
		wait_idle();
		repeat (20) @(posedge clk);
		if (failures == 0 && vertex_q.size() == 0)
			$display("greedy_rect_merge_quads_unit test passed");
		else
			$display("greedy_rect_merge_quads_unit test failed");
		$finish;
	end

endmodule
